// File: rtl/drgm_pkg.sv
package drgm_pkg;

    // grid geometry
    localparam int GRID_WIDTH  = 15;
    localparam int GRID_HEIGHT = 10;
    localparam int POS_W       = 4;
    localparam int TILE_W      = 8;

    localparam logic [POS_W-1:0] COL_MAX   = POS_W'(GRID_WIDTH - 1);
    localparam logic [POS_W-1:0] ROW_MAX   = POS_W'(GRID_HEIGHT - 1);
    localparam logic [POS_W-1:0] COL_RESET = POS_W'(7);
    localparam logic [POS_W-1:0] ROW_RESET = POS_W'(5);

    // timer and remainder unit widths
    localparam int MS_W      = 16;
    localparam int HOLD_W    = 18;
    localparam int DIV_STEPS = HOLD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // button bits
    localparam int BTN_A     = 0;
    localparam int BTN_B     = 1;
    localparam int BTN_SEL   = 2;
    localparam int BTN_START = 3;
    localparam int BTN_UP    = 4;
    localparam int BTN_DOWN  = 5;
    localparam int BTN_LEFT  = 6;
    localparam int BTN_RIGHT = 7;

    // configuration register reset values
    localparam logic [MS_W-1:0] RUN_PACE_RESET       = 16'd140;
    localparam logic [MS_W-1:0] WALK_PACE_RESET      = 16'd280;
    localparam logic [MS_W-1:0] RUN_DIAG_PACE_RESET  = 16'd196;
    localparam logic [MS_W-1:0] WALK_DIAG_PACE_RESET = 16'd393;
    localparam logic [MS_W-1:0] DEBOUNCE_RESET       = 16'd100;

    typedef enum logic [2:0] {
        REG_RUN_PACE       = 3'd0,
        REG_WALK_PACE      = 3'd1,
        REG_RUN_DIAG_PACE  = 3'd2,
        REG_WALK_DIAG_PACE = 3'd3,
        REG_DEBOUNCE       = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_WAIT = 2'd0,
        KIND_FACE = 2'd1,
        KIND_STEP = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_DEB_CHK,
        S_PACE_CHK,
        S_DIV,
        S_MOVE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rem_status_t;

    function automatic logic [MS_W-1:0] nonzero16(input logic [MS_W-1:0] v);
        return (v == '0) ? MS_W'(1) : v;
    endfunction

endpackage

// File: rtl/dpad_repeat_grid_mover.sv
// d-pad auto-repeat grid mover
//
// input channel (in_valid / in_stall): one item per frame, an 8-bit button
// word and the milliseconds since the previous frame. output channel
// (out_valid / out_stall): exactly one result item per input item, in order:
// move kind (wait, face, step), the tile index of the position after the
// frame, a redraw flag and a line-mode select.
// configuration: apb-style port, five 16-bit registers at byte addresses
// 0, 4, 8, 12, 16 (run, walk, diagonal run, diagonal walk pace, debounce).
// sequencing: a sequencer drives one shared add/compare and an 18-step
// restoring remainder unit (one quotient bit per cycle). the result is
// loaded into the output register in S_OUT, after S_FIRST, the debounce and
// pace checks as needed, S_DIV when the hold timer has to be reduced modulo
// the pace or debounce time, and S_MOVE; in_stall is high until the sequencer
// is back in S_IDLE, so a new item is taken only once the last is through it.
// stall: the result sits in an output register; a new item is accepted
// while it waits, and the sequencer holds its last state until the output
// register is free.
// reset: rst_n (async, active low) clears the hold timer and flags, puts the
// position at column 7 row 5 and loads the register reset values.
module dpad_repeat_grid_mover (
    input  logic                        clk,
    input  logic                        rst_n,
    // input item channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  buttons,
    input  logic [drgm_pkg::MS_W-1:0]   frame_ms,
    // result item channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  move_kind,
    output logic [drgm_pkg::TILE_W-1:0] tile_index,
    output logic                        redraw,
    output logic                        line_mode,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [4:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import drgm_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [MS_W-1:0] run_pace_reg;
    logic [MS_W-1:0] walk_pace_reg;
    logic [MS_W-1:0] run_diag_pace_reg;
    logic [MS_W-1:0] walk_diag_pace_reg;
    logic [MS_W-1:0] debounce_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_pace_reg       <= RUN_PACE_RESET;
            walk_pace_reg      <= WALK_PACE_RESET;
            run_diag_pace_reg  <= RUN_DIAG_PACE_RESET;
            walk_diag_pace_reg <= WALK_DIAG_PACE_RESET;
            debounce_reg       <= DEBOUNCE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_RUN_PACE:       run_pace_reg       <= pwdata[MS_W-1:0];
                REG_WALK_PACE:      walk_pace_reg      <= pwdata[MS_W-1:0];
                REG_RUN_DIAG_PACE:  run_diag_pace_reg  <= pwdata[MS_W-1:0];
                REG_WALK_DIAG_PACE: walk_diag_pace_reg <= pwdata[MS_W-1:0];
                REG_DEBOUNCE:       debounce_reg       <= pwdata[MS_W-1:0];
                default:            ; // unmapped addresses ignore writes
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_RUN_PACE:       prdata = {16'd0, run_pace_reg};
            REG_WALK_PACE:      prdata = {16'd0, walk_pace_reg};
            REG_RUN_DIAG_PACE:  prdata = {16'd0, run_diag_pace_reg};
            REG_WALK_DIAG_PACE: prdata = {16'd0, walk_diag_pace_reg};
            REG_DEBOUNCE:       prdata = {16'd0, debounce_reg};
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [7:0]        btn_reg, btn_next;          // buttons of the item at work
    logic [MS_W-1:0]   dt_reg, dt_next;
    logic [MS_W-1:0]   pace_reg, pace_next;        // pace picked at accept, never 0
    logic              diff_reg, diff_next;        // any button changed
    logic [7:0]        prev_btn_reg, prev_btn_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic              deb_flag_reg, deb_flag_next;
    logic [POS_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  row_reg, row_next;
    kind_t             kind_reg, kind_next;
    logic              moved_reg, moved_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    kind_t             o_kind_reg, o_kind_next;
    logic [TILE_W-1:0] o_tile_reg, o_tile_next;
    logic              o_redraw_reg, o_redraw_next;
    logic              o_line_reg, o_line_next;

    // remainder unit
    logic              div_start;
    rem_status_t       div_status;
    logic [MS_W-1:0]   div_rem;

    // shared add/compare unit
    logic [HOLD_W-1:0] hold_sum;
    logic [MS_W-1:0]   deb_eff;
    logic [MS_W-1:0]   cmp_val;
    logic              hold_ge;

    logic              in_acc;
    logic              out_free;
    logic [3:0]        dirs;
    logic              diag;
    logic [MS_W-1:0]   pace_sel;

    // moves of one step, applied up, down, left, right
    logic [POS_W-1:0]  step_row;
    logic [POS_W-1:0]  step_col;
    logic              step_moved;
    logic              redraw_now;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    assign deb_eff  = nonzero16(debounce_reg);
    assign cmp_val  = (state_reg == S_DEB_CHK) ? deb_eff : pace_reg;
    assign hold_sum = hold_reg + {{(HOLD_W-MS_W){1'b0}}, dt_reg};
    assign hold_ge  = (hold_reg >= {{(HOLD_W-MS_W){1'b0}}, cmp_val});

    // diagonal means exactly one vertical and one horizontal direction
    assign dirs = buttons[BTN_RIGHT:BTN_UP];
    always_comb
    begin
        unique case (dirs)
            4'b1001, 4'b0101, 4'b1010, 4'b0110: diag = 1'b1;
            default:                            diag = 1'b0;
        endcase
    end

    always_comb
    begin
        if (diag)
        begin
            pace_sel = buttons[BTN_B] ? run_diag_pace_reg : walk_diag_pace_reg;
        end
        else
        begin
            pace_sel = buttons[BTN_B] ? run_pace_reg : walk_pace_reg;
        end
    end

    always_comb
    begin
        step_row   = row_reg;
        step_col   = col_reg;
        step_moved = 1'b0;
        if (btn_reg[BTN_UP] && (step_row != '0))
        begin
            step_row   = step_row - POS_W'(1);
            step_moved = 1'b1;
        end
        if (btn_reg[BTN_DOWN] && (step_row < ROW_MAX))
        begin
            step_row   = step_row + POS_W'(1);
            step_moved = 1'b1;
        end
        if (btn_reg[BTN_LEFT] && (step_col != '0))
        begin
            step_col   = step_col - POS_W'(1);
            step_moved = 1'b1;
        end
        if (btn_reg[BTN_RIGHT] && (step_col < COL_MAX))
        begin
            step_col   = step_col + POS_W'(1);
            step_moved = 1'b1;
        end
    end

    assign redraw_now = moved_reg || diff_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                if (btn_reg[BTN_RIGHT:BTN_UP] == '0)
                begin
                    state_next = S_MOVE;
                end
                else if (!deb_flag_reg && (hold_reg == '0))
                begin
                    state_next = S_MOVE;
                end
                else
                begin
                    state_next = deb_flag_reg ? S_PACE_CHK : S_DEB_CHK;
                end
            end
            S_DEB_CHK:
            begin
                state_next = hold_ge ? S_DIV : S_PACE_CHK;
            end
            S_PACE_CHK:
            begin
                state_next = hold_ge ? S_DIV : S_MOVE;
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath updates per state
    always_comb
    begin
        btn_next       = btn_reg;
        dt_next        = dt_reg;
        pace_next      = pace_reg;
        diff_next      = diff_reg;
        prev_btn_next  = prev_btn_reg;
        hold_next      = hold_reg;
        deb_flag_next  = deb_flag_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        kind_next      = kind_reg;
        moved_next     = moved_reg;
        out_valid_next = out_valid_reg && out_stall;
        o_kind_next    = o_kind_reg;
        o_tile_next    = o_tile_reg;
        o_redraw_next  = o_redraw_reg;
        o_line_next    = o_line_reg;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    btn_next      = buttons;
                    dt_next       = frame_ms;
                    pace_next     = nonzero16(pace_sel);
                    diff_next     = (prev_btn_reg != buttons);
                    prev_btn_next = buttons;
                    kind_next     = KIND_WAIT;
                    moved_next    = 1'b0;
                end
            end
            S_FIRST:
            begin
                if (btn_reg[BTN_RIGHT:BTN_UP] == '0)
                begin
                    // no direction held: timer and debounce start over
                    hold_next     = '0;
                    deb_flag_next = 1'b0;
                end
                else if (!deb_flag_reg && (hold_reg == '0))
                begin
                    // first press only turns to face
                    hold_next = {{(HOLD_W-MS_W){1'b0}}, dt_reg};
                    kind_next = KIND_FACE;
                end
                else
                begin
                    hold_next = hold_sum;
                end
            end
            S_DEB_CHK:
            begin
                if (hold_ge)
                begin
                    deb_flag_next = 1'b1;
                    kind_next     = KIND_STEP;
                    div_start     = 1'b1;
                end
                else
                begin
                    // debounce not yet reached: the timer advances again
                    hold_next = hold_sum;
                end
            end
            S_PACE_CHK:
            begin
                if (hold_ge)
                begin
                    kind_next = KIND_STEP;
                    div_start = 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    hold_next = {{(HOLD_W-MS_W){1'b0}}, div_rem};
                end
            end
            S_MOVE:
            begin
                if (kind_reg == KIND_STEP)
                begin
                    row_next   = step_row;
                    col_next   = step_col;
                    moved_next = step_moved;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_kind_next    = kind_reg;
                    o_tile_next    = TILE_W'({4'd0, row_reg} * TILE_W'(GRID_WIDTH))
                                   + {{(TILE_W-POS_W){1'b0}}, col_reg};
                    o_redraw_next  = redraw_now;
                    o_line_next    = redraw_now && (btn_reg[BTN_A] || btn_reg[BTN_SEL]
                                                    || btn_reg[BTN_START]);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_btn_reg  <= '0;
            hold_reg      <= '0;
            deb_flag_reg  <= 1'b0;
            col_reg       <= COL_RESET;
            row_reg       <= ROW_RESET;
            kind_reg      <= KIND_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_btn_reg  <= prev_btn_next;
            hold_reg      <= hold_next;
            deb_flag_reg  <= deb_flag_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        btn_reg      <= btn_next;
        dt_reg       <= dt_next;
        pace_reg     <= pace_next;
        diff_reg     <= diff_next;
        moved_reg    <= moved_next;
        o_kind_reg   <= o_kind_next;
        o_tile_reg   <= o_tile_next;
        o_redraw_reg <= o_redraw_next;
        o_line_reg   <= o_line_next;
    end

    // serial remainder of the hold timer by pace or debounce time
    drgm_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (hold_reg),
        .divisor   (cmp_val),
        .status    (div_status),
        .remainder (div_rem)
    );

    assign out_valid  = out_valid_reg;
    assign move_kind  = o_kind_reg;
    assign tile_index = o_tile_reg;
    assign redraw     = o_redraw_reg;
    assign line_mode  = o_line_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the hold timer never needs its top bit: a second add only follows a sum below 2^16
    a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
        !hold_reg[HOLD_W-1])
        else $error("hold timer out of range");

    // the remainder unit is only started when idle
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("remainder unit restarted while busy");

    // while waiting on the remainder, the unit is working or finishing
    a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_status.busy || div_status.done))
        else $error("waiting on an idle remainder unit");

    // a step is only taken with a direction held
    a_step_dirs: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MOVE) && (kind_reg == KIND_STEP))
            |-> (btn_reg[BTN_RIGHT:BTN_UP] != '0))
        else $error("step without a direction held");

endmodule

// File: rtl/drgm_rem.sv
module drgm_rem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [drgm_pkg::HOLD_W-1:0]   dividend,
    input  logic [drgm_pkg::MS_W-1:0]     divisor,
    output drgm_pkg::rem_status_t         status,
    output logic [drgm_pkg::MS_W-1:0]     remainder
);
    import drgm_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [HOLD_W-1:0] dvd_reg, dvd_next;
    logic [MS_W-1:0]   dsr_reg, dsr_next;
    logic [MS_W-1:0]   rem_reg, rem_next;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    logic [MS_W:0] trial;
    logic [MS_W:0] trial_sub;
    logic          fits;

    assign trial     = {rem_reg, dvd_reg[HOLD_W-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign fits      = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_STEPS - 1);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_sub[MS_W-1:0] : trial[MS_W-1:0];
            dvd_next = {dvd_reg[HOLD_W-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule
